// ===== design/yphd_pkg.sv =====
// Package: shared constants and arithmetic helpers for the YUV pyramid half downscaler.
`timescale 1ns / 1ps
package yphd_pkg;
    localparam int MAX_WIDTH   = 1024;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int YUV_W       = 30;
    localparam int STORE_ROWS  = 4;
    localparam int WIN_N       = 5;
    localparam logic [10:0] LINE_WIDTH_RESET = 11'd512;
    localparam logic [10:0] WIDTH_MIN = 11'd3;
    localparam logic [10:0] WIDTH_MAX = 11'(MAX_WIDTH);

    typedef logic [YUV_W-1:0] t_yuv;

    // trunc toward zero of s / 2^14
    function automatic logic signed [9:0] trunc14(input logic signed [23:0] s);
        logic signed [23:0] a;
        begin
            a = s[23] ? s + 24'sd16383 : s;
            trunc14 = 10'(a >>> 14);
        end
    endfunction

    function automatic t_yuv to_yuv(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
        logic signed [23:0] sr, sg, sb, y, u, v;
        begin
            sr = 24'($signed({1'b0, r}));
            sg = 24'($signed({1'b0, g}));
            sb = 24'($signed({1'b0, b}));
            y = 24'sd4899 * sr + 24'sd9617 * sg + 24'sd1868 * sb + 24'sd14746;
            u = -24'sd2762 * sr - 24'sd5425 * sg + 24'sd8187 * sb + 24'sd14746;
            v = 24'sd8189 * sr - 24'sd6857 * sg - 24'sd1332 * sb + 24'sd14746;
            to_yuv = {trunc14(y), trunc14(u), trunc14(v)};
        end
    endfunction

    // s / 100 truncated toward zero, |s| <= 51200, by reciprocal 2^22 / 100
    function automatic logic signed [10:0] div100(input logic signed [17:0] s);
        logic [15:0] mag;
        logic [31:0] prod;
        logic [10:0] q;
        begin
            mag  = s[17] ? 16'(-s) : 16'(s);
            prod = 32'(mag) * 32'd41944;
            q    = 11'(prod >> 22);
            div100 = s[17] ? -$signed(q) : $signed(q);
        end
    endfunction

    function automatic logic [7:0] to_byte(input logic signed [27:0] t);
        logic [13:0] x;
        begin
            x = 14'(t >>> 14);
            if (t <= 0) begin
                to_byte = 8'd0;
            end else if (x > 14'd255) begin
                to_byte = 8'd255;
            end else begin
                to_byte = x[7:0];
            end
        end
    endfunction
endpackage

// ===== design/yphd_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module yphd_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/yuv_pyramid_half_downscaler.sv =====
// Top level: RGB to YUV, four line stores, pyramid filters, half-size RGB output.
// Throughput: one input pixel per cycle; the pipeline advances whenever the output
// register is empty or taken, and the only memory is four line RAMs read and written once per pixel.
// Reset (i_rst_n low, synchronous) clears counters, window taps and valids;
// line width returns to 512. Line RAM contents are not cleared.
`timescale 1ns / 1ps
module yuv_pyramid_half_downscaler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red, green, blue
    input  logic        s_axis_tuser,   // repeat_row
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
    output logic        m_axis_tlast    // last_in_row
);
    import yphd_pkg::*;

    logic        en, acc;
    logic [10:0] r_line_width, w;
    logic [9:0]  r_col, c;
    logic [1:0]  r_rows, r_pads, rs_eff, pads_eff;
    logic        r_par, par_eff;
    logic        rep, ignore, frame_restart, emit, shifted, even_hit, end_row;

    assign en = !(m_axis_tvalid && !m_axis_tready);
    assign s_axis_tready = en;
    assign acc = s_axis_tvalid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_line_width <= i_cfg_wdata;
        end
    end

    // stage 0: column and row bookkeeping
    always_comb begin
        w = (r_line_width < WIDTH_MIN) ? WIDTH_MIN :
            ((r_line_width > WIDTH_MAX) ? WIDTH_MAX : r_line_width);
        c = (11'(r_col) >= w) ? '0 : r_col;
        rep = s_axis_tuser;
        ignore = rep && (r_rows == 2'd0 || r_pads >= 2'd2);
        frame_restart = !rep && c == '0 && r_pads >= 2'd2;
        rs_eff  = frame_restart ? 2'd0 : r_rows;
        par_eff = frame_restart ? 1'b0 : r_par;
        pads_eff = (!rep && c == '0) ? 2'd0 : r_pads;
        even_hit = c >= 10'd2 && !c[0];
        end_row = 11'(c) == w - 11'd1;
        emit = rs_eff >= 2'd2 && !par_eff && (even_hit || (end_row && !w[0]));
        shifted = !even_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_rows <= '0;
            r_pads <= '0;
            r_par  <= 1'b0;
        end else if (acc && !ignore) begin
            if (11'(c) + 11'd1 >= w) begin
                r_col <= '0;
                r_par <= !par_eff;
                r_rows <= (rs_eff < 2'd2) ? rs_eff + 2'd1 : rs_eff;
                r_pads <= (rep && pads_eff < 2'd2) ? pads_eff + 2'd1 : pads_eff;
            end else begin
                r_col  <= c + 10'd1;
                r_rows <= rs_eff;
                r_par  <= par_eff;
                r_pads <= pads_eff;
            end
        end
    end

    // stage 1 registers
    logic              r_v1, r_rep1, r_rs01, r_c01, r_emit1, r_shift1, r_last1;
    logic [ADDR_W-1:0] r_c1;
    t_yuv              r_yuv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= acc && !ignore;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rep1   <= rep;
            r_rs01   <= rs_eff == 2'd0;
            r_c01    <= c == '0;
            r_emit1  <= emit;
            r_shift1 <= shifted;
            r_last1  <= end_row;
            r_c1     <= ADDR_W'(c);
            r_yuv1   <= to_yuv(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]);
        end
    end

    // line stores
    t_yuv q [STORE_ROWS];
    t_yuv cur;
    t_yuv vcol [WIN_N];

    always_comb begin
        cur = r_rep1 ? q[STORE_ROWS-1] : r_yuv1;
        for (int k = 0; k < STORE_ROWS; k++) begin
            vcol[k] = r_rs01 ? cur : q[k];
        end
        vcol[WIN_N-1] = cur;
    end

    for (genvar g = 0; g < STORE_ROWS; g++) begin : g_line
        yphd_ram #(
            .WIDTH(YUV_W),
            .DEPTH(MAX_WIDTH)
        ) u_line (
            .i_clk  (i_clk),
            .i_we   (en && r_v1),
            .i_waddr(r_c1),
            .i_wdata(vcol[g+1]),
            .i_re   (acc),
            .i_raddr(ADDR_W'(c)),
            .o_rdata(q[g])
        );
    end

    // window taps
    t_yuv r_taps [WIN_N][WIN_N];
    t_yuv n_taps [WIN_N][WIN_N];

    always_comb begin
        for (int k = 0; k < WIN_N; k++) begin
            for (int j = 0; j < WIN_N; j++) begin
                if (r_c01) begin
                    n_taps[k][j] = vcol[k];
                end else if (j == WIN_N - 1) begin
                    n_taps[k][j] = vcol[k];
                end else begin
                    n_taps[k][j] = r_taps[k][(j + 1) % WIN_N];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_N; k++) begin
                for (int j = 0; j < WIN_N; j++) begin
                    r_taps[k][j] <= '0;
                end
            end
        end else if (en && r_v1) begin
            r_taps <= n_taps;
        end
    end

    // stage 2: selected window
    t_yuv r_win [WIN_N][WIN_N];
    logic r_v2, r_last2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1 && r_emit1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last2 <= r_last1;
            for (int k = 0; k < WIN_N; k++) begin
                for (int j = 0; j < WIN_N; j++) begin
                    // near the right edge the window leans one column right
                    r_win[k][j] <= (r_shift1 && j < WIN_N - 1) ? n_taps[k][j+1] : n_taps[k][j];
                end
            end
        end
    end

    // stage 3: row sums
    logic signed [15:0] ru [WIN_N], rv [WIN_N], ry [WIN_N];
    logic signed [15:0] r_ru [WIN_N], r_rv [WIN_N], r_ry [WIN_N];
    logic r_v3, r_last3;

    always_comb begin
        for (int k = 0; k < WIN_N; k++) begin
            ru[k] = 16'($signed(r_win[k][0][19:10])) + 16'($signed(r_win[k][1][19:10])) * 2
                  + 16'($signed(r_win[k][2][19:10])) * 4 + 16'($signed(r_win[k][3][19:10])) * 2
                  + 16'($signed(r_win[k][4][19:10]));
            rv[k] = 16'($signed(r_win[k][0][9:0])) + 16'($signed(r_win[k][1][9:0])) * 2
                  + 16'($signed(r_win[k][2][9:0])) * 4 + 16'($signed(r_win[k][3][9:0])) * 2
                  + 16'($signed(r_win[k][4][9:0]));
            ry[k] = 16'($signed(r_win[k][1][29:20])) + 16'($signed(r_win[k][2][29:20])) * 2
                  + 16'($signed(r_win[k][3][29:20]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ru <= ru;
            r_rv <= rv;
            r_ry <= ry;
            r_last3 <= r_last2;
        end
    end

    // stage 4: column sums
    logic signed [17:0] r_su, r_sv;
    logic signed [15:0] r_sy;
    logic r_v4, r_last4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_su <= 18'(r_ru[0]) + 18'(r_ru[1]) * 2 + 18'(r_ru[2]) * 4
                  + 18'(r_ru[3]) * 2 + 18'(r_ru[4]);
            r_sv <= 18'(r_rv[0]) + 18'(r_rv[1]) * 2 + 18'(r_rv[2]) * 4
                  + 18'(r_rv[3]) * 2 + 18'(r_rv[4]);
            r_sy <= r_ry[1] + r_ry[2] * 2 + r_ry[3];
            r_last4 <= r_last3;
        end
    end

    // stage 5: divisions, toward zero
    logic signed [15:0] sy_adj;
    logic signed [10:0] r_y5, r_u5, r_v5;
    logic r_v5v, r_last5;

    assign sy_adj = r_sy[15] ? r_sy + 16'sd15 : r_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5v <= 1'b0;
        end else if (en) begin
            r_v5v <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y5 <= 11'(sy_adj >>> 4);
            r_u5 <= div100(r_su);
            r_v5 <= div100(r_sv);
            r_last5 <= r_last4;
        end
    end

    // stage 6: back to RGB in signed Q14.14
    logic signed [27:0] r_tr, r_tg, r_tb;
    logic r_v6, r_last6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v6 <= r_v5v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tr <= 28'sd16384 * 28'(r_y5) + 28'sd22980 * 28'(r_v5);
            r_tg <= 28'sd16384 * 28'(r_y5) - 28'sd5643 * 28'(r_u5) - 28'sd11705 * 28'(r_v5);
            r_tb <= 28'sd16384 * 28'(r_y5) + 28'sd29049 * 28'(r_u5);
            r_last6 <= r_last5;
        end
    end

    // output register
    logic        r_out_valid, r_out_last;
    logic [23:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {to_byte(r_tb), to_byte(r_tg), to_byte(r_tr)};
            r_out_last <= r_last6;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
endmodule

// ===== test/yuv_pyramid_half_downscaler_checker.sv =====
// Checker: predicts half-size RGB output from observed input transactions and compares.
`timescale 1ns / 1ps
module yuv_pyramid_half_downscaler_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red, green, blue
    input  logic        s_axis_tuser,   // repeat_row
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
    input  logic        m_axis_tlast,   // last_in_row
    output int          o_fail_count,
    output int          o_pending,
    output int          o_pixels_out
);
    import yphd_pkg::*;

    typedef struct packed {
        logic [23:0] rgb;
        logic        last;
    } t_pixel_out;

    t_pixel_out  pixel_q[$];
    t_yuv        line_mem[STORE_ROWS][MAX_WIDTH];
    t_yuv        taps[WIN_N][5];
    logic [10:0] width_reg;
    int          col;
    int          rows_in;
    logic        odd_row;
    int          pad_rows;

    function automatic int shr14(int s);
        return (s < 0) ? -((-s) >>> 14) : (s >>> 14);
    endfunction

    function automatic int fld(t_yuv p, int sh);
        logic signed [9:0] f;
        f = p[sh +: 10];
        return int'(f);
    endfunction

    function automatic t_yuv rgb2yuv(int r, int g, int b);
        int y, u, v;
        y = shr14(4899 * r + 9617 * g + 1868 * b + 14746);
        u = shr14(-2762 * r - 5425 * g + 8187 * b + 14746);
        v = shr14(8189 * r - 6857 * g - 1332 * b + 14746);
        return {y[9:0], u[9:0], v[9:0]};
    endfunction

    function automatic logic [7:0] clip8(int t);
        int x;
        if (t <= 0) return 8'd0;
        x = t >>> 14;
        return (x > 255) ? 8'd255 : x[7:0];
    endfunction

    // one input pixel through the downscaler state
    task automatic downscale_pixel(input logic [23:0] d, input logic rep);
        int w, c, k, j, src, m, sy, su, sv, y, u, v;
        int wt[5];
        t_yuv cur;
        t_yuv vcol[WIN_N];
        bit emit, shifted;
        t_pixel_out px;
        wt = '{1, 2, 4, 2, 1};
        w = (width_reg < WIDTH_MIN) ? 3 : ((width_reg > WIDTH_MAX) ? MAX_WIDTH : width_reg);
        emit = 0;
        shifted = 0;
        if (col >= w) col = 0;
        c = col;
        if (rep) begin
            if (rows_in == 0 || pad_rows >= 2) return;
            cur = line_mem[3][c];
        end else begin
            if (c == 0 && pad_rows >= 2) begin
                rows_in = 0;
                odd_row = 0;
            end
            if (c == 0) pad_rows = 0;
            cur = rgb2yuv(d[7:0], d[15:8], d[23:16]);
        end
        for (k = 0; k < 4; k++) vcol[k] = (rows_in == 0) ? cur : line_mem[k][c];
        vcol[4] = cur;
        for (k = 0; k < 4; k++) line_mem[k][c] = vcol[k + 1];
        for (k = 0; k < WIN_N; k++) begin
            if (c == 0) begin
                for (j = 0; j < 5; j++) taps[k][j] = vcol[k];
            end else begin
                for (j = 0; j < 4; j++) taps[k][j] = taps[k][j + 1];
                taps[k][4] = vcol[k];
            end
        end
        if (rows_in >= 2 && !odd_row) begin
            if (c >= 2 && c % 2 == 0) begin
                emit = 1;
            end else if (c == w - 1 && w % 2 == 0) begin
                emit = 1;
                shifted = 1;
            end
        end
        if (emit) begin
            sy = 0;
            su = 0;
            sv = 0;
            for (k = 0; k < 5; k++) begin
                for (j = 0; j < 5; j++) begin
                    src = shifted ? ((j + 1 > 4) ? 4 : j + 1) : j;
                    m = wt[k] * wt[j];
                    su += m * fld(taps[k][src], 10);
                    sv += m * fld(taps[k][src], 0);
                    if (k >= 1 && k <= 3 && j >= 1 && j <= 3)
                        sy += (wt[k] / 2) * (wt[j] / 2) * fld(taps[k][src], 20);
                end
            end
            y = sy / 16;
            u = su / 100;
            v = sv / 100;
            px.rgb = {clip8(16384 * y + 29049 * u),
                      clip8(16384 * y - 5643 * u - 11705 * v),
                      clip8(16384 * y + 22980 * v)};
            px.last = (c == w - 1);
            pixel_q.push_back(px);
        end
        if (c + 1 >= w) begin
            col = 0;
            odd_row = ~odd_row;
            if (rows_in < 2) rows_in++;
            if (rep && pad_rows < 2) pad_rows++;
        end else begin
            col = c + 1;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pixels_out = 0;
        o_pending = 0;
        foreach (line_mem[k, j]) line_mem[k][j] = '0;
    end

    always @(posedge i_clk) begin
        t_pixel_out exp_px;
        if (!i_rst_n) begin
            pixel_q.delete();
            foreach (taps[k, j]) taps[k][j] = '0;
            col = 0;
            rows_in = 0;
            odd_row = 0;
            pad_rows = 0;
            width_reg = LINE_WIDTH_RESET;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                o_pixels_out++;
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected output pixel %h last %b", $time,
                             m_axis_tdata, m_axis_tlast);
                    o_fail_count++;
                end else begin
                    exp_px = pixel_q.pop_front();
                    if (exp_px.rgb !== m_axis_tdata || exp_px.last !== m_axis_tlast) begin
                        $display("%0t: pixel mismatch expected %h last %b, got %h last %b",
                                 $time, exp_px.rgb, exp_px.last, m_axis_tdata, m_axis_tlast);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) downscale_pixel(s_axis_tdata, s_axis_tuser);
            if (i_cfg_we) width_reg = i_cfg_wdata;
        end
        o_pending = pixel_q.size();
    end
endmodule

// ===== test/yuv_pyramid_half_downscaler_tb.sv =====
// Testbench top: drives frames of RGB pixels and line width settings, reports the verdict.
`timescale 1ns / 1ps
module yuv_pyramid_half_downscaler_tb;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [10:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;
    int          pixels_out;
    int          burst_left;
    int          pixels_in;
    int          frames;
    int          cur_width;

    yuv_pyramid_half_downscaler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    yuv_pyramid_half_downscaler_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .o_fail_count(fail_count), .o_pending(pending), .o_pixels_out(pixels_out)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    // receiver stall pattern: modes switch every so often
    initial begin
        int mode, left;
        m_axis_tready = 0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 120);
            end
            left--;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic send_pixel(input logic [23:0] d, input logic rep);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= rep;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        pixels_in++;
    endtask

    // write line width once all results are out and the pipeline has drained
    task automatic set_width(input logic [10:0] val);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_width = (val < 3) ? 3 : ((val > 1024) ? 1024 : val);
    endtask

    function automatic logic [23:0] rand_rgb();
        if ($urandom_range(0, 7) == 0)
            return {($urandom_range(0, 1) ? 8'hff : 8'h00), ($urandom_range(0, 1) ? 8'hff : 8'h00),
                    ($urandom_range(0, 1) ? 8'hff : 8'h00)};
        return 24'($urandom);
    endfunction

    // one frame: real rows, optional broken single pad row, two pad rows, stray pads
    task automatic send_frame(input int rows, input bit noisy);
        int r, c;
        if (noisy) repeat ($urandom_range(0, 3)) send_pixel(rand_rgb(), 1'b1);
        for (r = 0; r < rows; r++) begin
            for (c = 0; c < cur_width; c++)
                send_pixel(rand_rgb(), noisy && r > 0 && c != cur_width - 1
                                       && $urandom_range(0, 9) == 0);
            if (noisy && r > 0 && r < rows - 1 && $urandom_range(0, 3) == 0)
                for (c = 0; c < cur_width; c++) send_pixel(rand_rgb(), 1'b1);
        end
        for (r = 0; r < 2 * cur_width; r++) send_pixel(rand_rgb(), 1'b1);
        if (noisy) repeat ($urandom_range(0, 3)) send_pixel(rand_rgb(), 1'b1);
        frames++;
    endtask

    initial begin
        logic [10:0] widths[8];
        widths = '{11'd0, 11'd2, 11'd3, 11'd4, 11'd5, 11'd7, 11'd2047, 11'd1024};
        i_rst_n       = 0;
        i_cfg_we      = 0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 0;
        burst_left    = 0;
        pixels_in     = 0;
        frames        = 0;
        cur_width     = 512;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: minimum width, color extremes, pads before any data
        set_width(11'd3);
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hffffff, 1'b0);
        send_pixel(24'h0000ff, 1'b0);
        send_pixel(24'h00ff00, 1'b0);
        send_pixel(24'hff0000, 1'b0);
        send_pixel(24'hff00ff, 1'b0);
        send_pixel(24'h00ffff, 1'b0);
        send_pixel(24'hffff00, 1'b0);
        send_pixel(24'h808080, 1'b0);
        repeat (6) send_pixel(24'h123456, 1'b1);
        send_pixel(24'hffffff, 1'b1);
        set_width(11'd4);
        repeat (4) send_pixel(24'hffffff, 1'b0);
        repeat (4) send_pixel(24'h000000, 1'b0);
        repeat (8) send_pixel(24'h000000, 1'b1);

        // widest line, one real row; the frame goes on at the next, narrower width
        set_width(11'd1024);
        for (int c = 0; c < 1024; c++) send_pixel(rand_rgb(), 1'b0);

        while (pixels_in < 1500) begin
            if ($urandom_range(0, 2) == 0)
                set_width(($urandom_range(0, 3) == 0) ? widths[$urandom_range(0, 7)]
                                                      : 11'($urandom_range(3, 24)));
            if (cur_width > 64) set_width(11'($urandom_range(3, 40)));
            send_frame($urandom_range(1, 7), $urandom_range(0, 3) != 0);
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("Sent %0d pixels in %0d frames, checked %0d output pixels.",
                 pixels_in, frames, pixels_out);
        $display("Widths from clamped minimum to maximum, padding and stray pad pixels.");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
